// File: hw/rtl/plms_pkg.sv
package plms_pkg;

    localparam int unsigned HOLD_CFG_W = 16;
    localparam int unsigned SEL_W      = 4;
    localparam int unsigned CFG_ADDR_W = 3;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_SHORT_HOLD   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MEDIUM_HOLD  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_LONG_HOLD    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_MODE_COUNT   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SERIES_COUNT = 3'd4;

    // Reset values
    localparam logic [HOLD_CFG_W-1:0] RST_SHORT_HOLD   = 16'd10;
    localparam logic [HOLD_CFG_W-1:0] RST_MEDIUM_HOLD  = 16'd100;
    localparam logic [HOLD_CFG_W-1:0] RST_LONG_HOLD    = 16'd500;
    localparam logic [SEL_W-1:0]      RST_MODE_COUNT   = 4'd14;
    localparam logic [SEL_W-1:0]      RST_SERIES_COUNT = 4'd11;
    localparam logic [SEL_W-1:0]      SEL_FIRST        = 4'd1;

    // Item kinds (input tuser)
    localparam logic KIND_SAMPLE  = 1'b0;
    localparam logic KIND_PATTERN = 1'b1;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_POWER  = 2'd1,
        ACT_MODE   = 2'd2,
        ACT_SERIES = 2'd3
    } t_action;

    typedef struct packed {
        logic [HOLD_CFG_W-1:0] short_hold;
        logic [HOLD_CFG_W-1:0] medium_hold;
        logic [HOLD_CFG_W-1:0] long_hold;
        logic [SEL_W-1:0]      mode_count;
        logic [SEL_W-1:0]      series_count;
    } t_cfg;

    typedef struct packed {
        logic             last_pressed;
        logic [SEL_W-1:0] mode;
        logic [SEL_W-1:0] series;
        logic             auto_cycle;
        logic             power_high;
    } t_sel_state;

    // Increment with wrap back to one once the count is passed
    function automatic logic [SEL_W-1:0] wrap_inc(input logic [SEL_W-1:0] v,
                                                  input logic [SEL_W-1:0] count);
        logic [SEL_W:0] n;
        n = {1'b0, v} + {{SEL_W{1'b0}}, 1'b1};
        if (n > {1'b0, count}) begin
            return SEL_FIRST;
        end
        return n[SEL_W-1:0];
    endfunction

endpackage

// File: hw/rtl/plms_step.sv
module plms_step #(
    parameter int unsigned HOLD_BITS = 16
) (
    input  plms_pkg::t_cfg       i_cfg,
    input  plms_pkg::t_sel_state i_state,
    input  logic [HOLD_BITS-1:0] i_hold,
    input  logic                 i_kind,
    input  logic                 i_level,
    output plms_pkg::t_sel_state o_state,
    output logic [HOLD_BITS-1:0] o_hold,
    output plms_pkg::t_action    o_action
);

    localparam int unsigned CMP_W =
        (HOLD_BITS > plms_pkg::HOLD_CFG_W) ? HOLD_BITS : plms_pkg::HOLD_CFG_W;

    logic                 pressed;
    logic [HOLD_BITS-1:0] hold_inc;
    logic [CMP_W-1:0]     hold_x;
    logic [CMP_W-1:0]     short_x;
    logic [CMP_W-1:0]     medium_x;
    logic [CMP_W-1:0]     long_x;
    logic [plms_pkg::SEL_W:0] series_n;

    assign pressed  = ~i_level;
    assign hold_inc = (pressed && (i_hold != {HOLD_BITS{1'b1}})) ?
                      i_hold + {{(HOLD_BITS-1){1'b0}}, 1'b1} : i_hold;
    assign hold_x   = CMP_W'(hold_inc);
    assign short_x  = CMP_W'(i_cfg.short_hold);
    assign medium_x = CMP_W'(i_cfg.medium_hold);
    assign long_x   = CMP_W'(i_cfg.long_hold);
    assign series_n = {1'b0, i_state.series} + {{plms_pkg::SEL_W{1'b0}}, 1'b1};

    always_comb begin
        o_state  = i_state;
        o_hold   = i_hold;
        o_action = plms_pkg::ACT_NONE;
        if (i_kind == plms_pkg::KIND_PATTERN) begin
            if (i_state.auto_cycle) begin
                o_state.series = plms_pkg::wrap_inc(i_state.series, i_cfg.series_count);
            end
        end else begin
            o_hold = hold_inc;
            o_state.last_pressed = pressed;
            // second idle sample in a row: classify the finished press
            if (!pressed && !i_state.last_pressed) begin
                o_hold = '0;
                if (hold_x > long_x) begin
                    o_state.power_high = ~i_state.power_high;
                    o_action = plms_pkg::ACT_POWER;
                end else if (hold_x > medium_x) begin
                    o_state.mode = plms_pkg::wrap_inc(i_state.mode, i_cfg.mode_count);
                    o_action = plms_pkg::ACT_MODE;
                end else if (hold_x > short_x) begin
                    o_action = plms_pkg::ACT_SERIES;
                    if (i_state.auto_cycle) begin
                        o_state.auto_cycle = 1'b0;
                        o_state.series     = plms_pkg::SEL_FIRST;
                    end else if (series_n > {1'b0, i_cfg.series_count}) begin
                        o_state.auto_cycle = 1'b1;
                        o_state.series     = plms_pkg::SEL_FIRST;
                    end else begin
                        o_state.series = series_n[plms_pkg::SEL_W-1:0];
                    end
                end
            end
        end
    end

endmodule

// File: hw/rtl/press_length_mode_selector_top.sv
// Press length mode selector.
// Input stream: one word per button sample tick or pattern-run-finished event.
//   s_axis_tuser  = kind (0 sample tick, 1 pattern finished)
//   s_axis_tdata  = bit 0 raw active-low button level (ignored for events)
// Output stream: one word per input word, carrying the selection after it
//   plus the action the word caused (none, power toggle, mode, series step).
// Config port: i_cfg_we writes i_cfg_wdata into register i_cfg_addr
//   (0 short_hold, 1 medium_hold, 2 long_hold, 3 mode_count, 4 series_count);
//   other indexes are dropped. Write only while the block is idle.
// Output: the result word is registered and valid in the cycle after the input word is taken.
// Throughput: one word per cycle while the output is not stalled; the hold counter, thresholds and selection
//   state update in a single step, so back-to-back words are accepted.
// Stall: the output register holds its word while m_axis_tready is low; input
//   is still accepted in the cycle the held word leaves, and stalls otherwise.
// Reset (synchronous, active low): thresholds 10/100/500, counts 14/11,
//   mode and series 1, auto-cycle off, power high, hold counter cleared,
//   output empty.
module press_length_mode_selector_top #(
    parameter int unsigned HOLD_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] button_level, [7:1] zero
    input  logic        s_axis_tuser,   // [0] mode (item kind)
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [3:0] current_mode, [7:4] current_series,
                                        // [8] auto_cycle, [9] power_high,
                                        // [11:10] action, [15:12] zero
);

    plms_pkg::t_cfg       r_cfg;
    plms_pkg::t_sel_state r_state;
    plms_pkg::t_sel_state n_state;
    logic [HOLD_BITS-1:0] r_hold;
    logic [HOLD_BITS-1:0] n_hold;
    plms_pkg::t_action    n_action;
    logic                 r_out_valid;
    logic [15:0]          r_out_data;
    logic                 accept;

    // output slot frees when empty or being drained this cycle
    assign s_axis_tready = ~r_out_valid | m_axis_tready;
    assign accept        = s_axis_tvalid & s_axis_tready;

    plms_step #(
        .HOLD_BITS (HOLD_BITS)
    ) u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_hold   (r_hold),
        .i_kind   (s_axis_tuser),
        .i_level  (s_axis_tdata[0]),
        .o_state  (n_state),
        .o_hold   (n_hold),
        .o_action (n_action)
    );

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_hold   <= plms_pkg::RST_SHORT_HOLD;
            r_cfg.medium_hold  <= plms_pkg::RST_MEDIUM_HOLD;
            r_cfg.long_hold    <= plms_pkg::RST_LONG_HOLD;
            r_cfg.mode_count   <= plms_pkg::RST_MODE_COUNT;
            r_cfg.series_count <= plms_pkg::RST_SERIES_COUNT;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                plms_pkg::REG_SHORT_HOLD: begin
                    r_cfg.short_hold <= i_cfg_wdata;
                end
                plms_pkg::REG_MEDIUM_HOLD: begin
                    r_cfg.medium_hold <= i_cfg_wdata;
                end
                plms_pkg::REG_LONG_HOLD: begin
                    r_cfg.long_hold <= i_cfg_wdata;
                end
                plms_pkg::REG_MODE_COUNT: begin
                    r_cfg.mode_count <= i_cfg_wdata[plms_pkg::SEL_W-1:0];
                end
                plms_pkg::REG_SERIES_COUNT: begin
                    r_cfg.series_count <= i_cfg_wdata[plms_pkg::SEL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // selection state and hold counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.last_pressed <= 1'b0;
            r_state.mode         <= plms_pkg::SEL_FIRST;
            r_state.series       <= plms_pkg::SEL_FIRST;
            r_state.auto_cycle   <= 1'b0;
            r_state.power_high   <= 1'b1;
            r_hold               <= '0;
        end else if (accept) begin
            r_state <= n_state;
            r_hold  <= n_hold;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= {4'd0, n_action, n_state.power_high, n_state.auto_cycle,
                           n_state.series, n_state.mode};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
